### hw/rtl/cpa_pkg.sv
`default_nettype none

package cpa_pkg;

	localparam int ANGLE_W = 32;
	localparam int COS_W   = 32;
	localparam int UA_W    = 32;
	localparam int QE_W    = 6;
	localparam int REM_W   = 27;
	localparam int R_W     = 26;
	localparam int SQ_W    = 52;
	localparam int ACC_W   = 64;
	localparam int MUL_W   = 60;
	localparam int S_SPLIT = 26;
	localparam int H_SPLIT = 29;
	localparam int PROD_W  = SQ_W + MUL_W;
	localparam int RES_W   = ACC_W - 30;
	localparam int N_STEPS = 7;

	localparam logic [R_W-1:0]   PI_Q24      = 26'd52707168;
	localparam logic [12:0]      RECIP       = 13'd5215;
	localparam int               RECIP_SHIFT = 38;
	localparam logic [ACC_W-1:0] ONE_Q60     = 64'h1000_0000_0000_0000;
	localparam logic [ACC_W-1:0] RND_Q30     = 64'd536870912;
	localparam logic [PROD_W-1:0] RND_Q48    = {{(PROD_W-48){1'b0}}, 1'b1, 47'd0};
	localparam logic signed [RES_W-1:0] RES_ONE = 34'sd1073741824;
	localparam logic signed [COS_W-1:0] ONE_Q30 = 32'sd1073741824;

	localparam logic signed [ACC_W-1:0] HORNER_INIT = -64'sd13096782;

	typedef logic signed [ACC_W-1:0] coef_arr_t [N_STEPS];

	localparam coef_arr_t STEP_COEF = '{
		64'sd2406807022,
		-64'sd317714203249,
		64'sd28594283334422,
		-64'sd1601279867507806,
		64'sd48038396025285216,
		64'sd0,
		64'sd0
	};

	typedef struct packed {
		logic                    odd;
		logic [SQ_W-1:0]         s;
		logic signed [ACC_W-1:0] h;
	} cpa_item_t;

endpackage

`default_nettype wire

### hw/rtl/cpa_mstep.sv
`default_nettype none

module cpa_mstep
	import cpa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic signed [ACC_W-1:0] coef,
	input  wire logic                    up_valid,
	output logic                         up_ready,
	input  wire cpa_item_t               up_item,
	output logic                         dn_valid,
	input  wire logic                    dn_ready,
	output cpa_item_t                    dn_item
);

	logic en1, en2, en3;
	logic v1_s1, v2_s2, v3_s3;

	logic [S_SPLIT-1:0]            s_lo, s_hi;
	logic [H_SPLIT-1:0]            h_lo;
	logic signed [MUL_W-H_SPLIT-1:0] h_hi;

	logic [S_SPLIT+H_SPLIT-1:0]          pp_ll_s1, pp_hl_s1;
	logic signed [MUL_W-H_SPLIT+S_SPLIT:0] pp_lh_s1, pp_hh_s1;
	logic                                neg_s1, odd_s1, odd_s2, odd_s3;
	logic [SQ_W-1:0]                     s_s1, s_s2, s_s3;
	logic [PROD_W-1:0]                   t_hh, t_lh, t_hl, t_ll, sum_c, sum_s2;
	logic signed [ACC_W-1:0]             h_s3;

	assign en3      = ~v3_s3 | dn_ready;
	assign en2      = ~v2_s2 | en3;
	assign en1      = ~v1_s1 | en2;
	assign up_ready = en1;
	assign dn_valid = v3_s3;

	assign s_lo = up_item.s[S_SPLIT-1:0];
	assign s_hi = up_item.s[SQ_W-1:S_SPLIT];
	assign h_lo = up_item.h[H_SPLIT-1:0];
	assign h_hi = up_item.h[MUL_W-1:H_SPLIT];

	assign t_hh = {{(PROD_W-$bits(pp_hh_s1)){pp_hh_s1[$bits(pp_hh_s1)-1]}}, pp_hh_s1}
		<< (S_SPLIT + H_SPLIT);
	assign t_lh = {{(PROD_W-$bits(pp_lh_s1)){pp_lh_s1[$bits(pp_lh_s1)-1]}}, pp_lh_s1}
		<< H_SPLIT;
	assign t_hl = {{(PROD_W-$bits(pp_hl_s1)){1'b0}}, pp_hl_s1} << S_SPLIT;
	assign t_ll = {{(PROD_W-$bits(pp_ll_s1)){1'b0}}, pp_ll_s1};

	// signed round half away from zero: subtract one before the shift when negative
	assign sum_c = t_hh + t_lh + t_hl + t_ll + RND_Q48 - {{(PROD_W-1){1'b0}}, neg_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= up_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pp_ll_s1 <= s_lo * h_lo;
			pp_hl_s1 <= s_hi * h_lo;
			pp_lh_s1 <= $signed({1'b0, s_lo}) * h_hi;
			pp_hh_s1 <= $signed({1'b0, s_hi}) * h_hi;
			neg_s1   <= up_item.h[MUL_W-1] & (|up_item.s);
			odd_s1   <= up_item.odd;
			s_s1     <= up_item.s;
		end
		if (en2) begin
			sum_s2 <= sum_c;
			odd_s2 <= odd_s1;
			s_s2   <= s_s1;
		end
		if (en3) begin
			h_s3   <= coef + $signed(sum_s2[PROD_W-1:48]);
			odd_s3 <= odd_s2;
			s_s3   <= s_s2;
		end
	end

	assign dn_item.odd = odd_s3;
	assign dn_item.s   = s_s3;
	assign dn_item.h   = h_s3;

endmodule

`default_nettype wire

### hw/rtl/cosine_poly_approx_core.sv
// Fixed-point cosine: takes a signed Q7.24 angle in radians and returns its cosine in Q1.30,
// saturated to +/-1.0. The angle is reduced by a truncating division by pi (3.141592), the
// cosine of the remainder comes from an even polynomial in r^2, and the sign flips on an odd
// quotient. The 29-stage pipeline takes one angle every cycle while angle_ready is high.
// Each of the seven Q48 multiplies takes three stages (partial products, sum and round,
// coefficient add). Stages that hold no item keep filling while cosine_ready is low, so
// angle_ready only drops once the pipeline is full and the output is stalled.
`default_nettype none

module cosine_poly_approx_core
	import cpa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    angle_valid,
	output logic                         angle_ready,
	input  wire logic signed [ANGLE_W-1:0] angle,
	output logic                         cosine_valid,
	input  wire logic                    cosine_ready,
	output logic signed [COS_W-1:0]      cosine
);

	logic en1, en2, en3, en4, en5, en27, en28, en29;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v27_s27, v28_s28, v29_s29;

	logic [UA_W-1:0]  ua_c, ua_s1, ua_s2;
	logic [44:0]      qp_c;
	logic [QE_W-1:0]  qe_s2;
	logic [UA_W-1:0]  rem_c;
	logic [REM_W-1:0] rem_s3, rem_sub;
	logic             par_s3, ge_c;
	logic [R_W-1:0]   r_s4;
	logic             odd_s4, odd_s5;
	logic [SQ_W-1:0]  s_s5;

	logic      sv [N_STEPS+1];
	logic      sr [N_STEPS+1];
	cpa_item_t sd [N_STEPS+1];

	logic [ACC_W-1:0]        s_sh;
	logic signed [ACC_W-1:0] v_s27;
	logic [ACC_W-1:0]        rsum_c;
	logic signed [RES_W-1:0] res_s28;
	logic signed [COS_W-1:0] cl_c;
	logic                    odd_s27, odd_s28;
	logic signed [COS_W-1:0] cos_s29;

	assign en29 = ~v29_s29 | cosine_ready;
	assign en28 = ~v28_s28 | en29;
	assign en27 = ~v27_s27 | en28;
	assign en5  = ~v5_s5 | sr[0];
	assign en4  = ~v4_s4 | en5;
	assign en3  = ~v3_s3 | en4;
	assign en2  = ~v2_s2 | en3;
	assign en1  = ~v1_s1 | en2;

	assign angle_ready  = en1;
	assign cosine_valid = v29_s29;
	assign cosine       = cos_s29;

	assign ua_c    = angle[ANGLE_W-1] ? (~angle + 32'd1) : angle;
	assign qp_c    = 45'(ua_s1) * 45'(RECIP);
	assign rem_c   = ua_s2 - 32'(qe_s2) * 32'(PI_Q24);
	assign ge_c    = rem_s3 >= REM_W'(PI_Q24);
	assign rem_sub = rem_s3 - REM_W'(PI_Q24);

	assign sv[0]     = v5_s5;
	assign sd[0].odd = odd_s5;
	assign sd[0].s   = s_s5;
	assign sd[0].h   = HORNER_INIT;
	assign sr[N_STEPS] = en27;

	for (genvar g = 0; g < N_STEPS; g++) begin : g_step
		cpa_mstep u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.coef     (STEP_COEF[g]),
			.up_valid (sv[g]),
			.up_ready (sr[g]),
			.up_item  (sd[g]),
			.dn_valid (sv[g+1]),
			.dn_ready (sr[g+1]),
			.dn_item  (sd[g+1])
		);
	end

	assign s_sh   = {1'b0, sd[N_STEPS].s, 11'd0};
	assign rsum_c = v_s27 + RND_Q30 - {{(ACC_W-1){1'b0}}, v_s27[ACC_W-1]};

	always_comb begin
		if (res_s28 > RES_ONE) begin
			cl_c = ONE_Q30;
		end else if (res_s28 < -RES_ONE) begin
			cl_c = -ONE_Q30;
		end else begin
			cl_c = res_s28[COS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			v5_s5   <= 1'b0;
			v27_s27 <= 1'b0;
			v28_s28 <= 1'b0;
			v29_s29 <= 1'b0;
		end else begin
			if (en1)  v1_s1   <= angle_valid;
			if (en2)  v2_s2   <= v1_s1;
			if (en3)  v3_s3   <= v2_s2;
			if (en4)  v4_s4   <= v3_s3;
			if (en5)  v5_s5   <= v4_s4;
			if (en27) v27_s27 <= sv[N_STEPS];
			if (en28) v28_s28 <= v27_s27;
			if (en29) v29_s29 <= v28_s28;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) ua_s1 <= ua_c;
		if (en2) begin
			ua_s2 <= ua_s1;
			qe_s2 <= qp_c[RECIP_SHIFT+QE_W-1:RECIP_SHIFT];
		end
		if (en3) begin
			rem_s3 <= rem_c[REM_W-1:0];
			par_s3 <= qe_s2[0];
		end
		if (en4) begin
			r_s4   <= ge_c ? rem_sub[R_W-1:0] : rem_s3[R_W-1:0];
			odd_s4 <= par_s3 ^ ge_c;
		end
		if (en5) begin
			s_s5   <= SQ_W'(r_s4) * SQ_W'(r_s4);
			odd_s5 <= odd_s4;
		end
		if (en27) begin
			v_s27   <= ONE_Q60 - s_sh + sd[N_STEPS].h;
			odd_s27 <= sd[N_STEPS].odd;
		end
		if (en28) begin
			res_s28 <= rsum_c[ACC_W-1:30];
			odd_s28 <= odd_s27;
		end
		if (en29) cos_s29 <= odd_s28 ? -cl_c : cl_c;
	end

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		cosine_valid |-> (cosine <= ONE_Q30 && cosine >= -ONE_Q30))
		else $error("cosine outside +/-1.0");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> (rem_s3 < REM_W'(2 * 52707168)))
		else $error("quotient estimate off by more than one");

	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v4_s4 |-> (r_s4 < PI_Q24))
		else $error("reduced angle not below pi");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v5_s5 && !en5) |=> (v5_s5 && $stable(s_s5) && $stable(odd_s5)))
		else $error("stalled item lost in square stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && angle_ready) |=> v1_s1)
		else $error("accepted item missing from first stage");

endmodule

`default_nettype wire
